// ----- hdl/nau_pkg.sv -----
`timescale 1ns / 1ps
// nau_pkg: widths, mode codes and the sigmoid lookup table for the activation unit
// depends on nothing; used by nau_sigmoid and neural_activation_unit_top

package nau_pkg;

    localparam int DATA_WIDTH    = 16;
    localparam int FRAC_BITS     = 12;
    localparam int TABLE_BITS    = 8;
    localparam int TABLE_ENTRIES = 1 << TABLE_BITS;

    // sigmoid values lie in [0, 1], so one integer bit above the fraction
    localparam int SIG_W     = FRAC_BITS + 1;
    localparam int MAG_W     = DATA_WIDTH + 1;
    localparam int SPAN_Q    = 8 << FRAC_BITS;
    localparam int IDX_SHIFT = FRAC_BITS + 3 - TABLE_BITS;
    localparam int ROM_IDX_W = TABLE_BITS + 1;

    // leaky slope 41/4096
    localparam int LEAK_NUM   = 41;
    localparam int LEAK_SHIFT = 12;
    localparam int LEAK_W     = DATA_WIDTH + 7;

    localparam int APB_DW = 32;
    localparam int APB_AW = 3;
    localparam int MODE_W = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_IDENTITY = 3'd0,
        MODE_SIGMOID  = 3'd1,
        MODE_TANH     = 3'd2,
        MODE_RELU     = 3'd3,
        MODE_LEAKY    = 3'd4
    } t_mode;

    // register index, taken from paddr[2]
    localparam logic REG_MODE = 1'b0;

    typedef logic [SIG_W-1:0] t_sig_rom [0:TABLE_ENTRIES];

    // shift-and-subtract quotient, only used while the table is built
    function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] dvs);
        logic [63:0] rem;
        logic [63:0] quo;
        int          b;
        rem = '0;
        quo = '0;
        for (b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= dvs) begin
                rem    = rem - dvs;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // elaboration-time table: entry i = round(1 / (1 + exp(-8i/N))) in Q.FRAC_BITS,
    // exp stepped in Q1.31 with a 24-term series for the step factor
    function automatic t_sig_rom build_sig_rom();
        t_sig_rom   rom;
        logic [63:0] d;
        logic [63:0] term;
        logic [63:0] q;
        logic [63:0] e;
        logic [63:0] den;
        int          k;
        int          i;
        d    = 64'd1 << (34 - TABLE_BITS);
        term = 64'd1 << 31;
        q    = 64'd1 << 31;
        e    = 64'd1 << 31;
        for (k = 1; k <= 24; k++) begin
            term = udiv64((term * d + (64'd1 << 30)) >> 31, 64'(k));
            if (k[0]) begin
                q = q - term;
            end else begin
                q = q + term;
            end
        end
        for (i = 0; i <= TABLE_ENTRIES; i++) begin
            if (i > 0) begin
                e = (e * q + (64'd1 << 30)) >> 31;
            end
            den    = (64'd1 << 31) + e;
            rom[i] = SIG_W'(udiv64((64'd1 << (FRAC_BITS + 31)) + (den >> 1), den));
        end
        return rom;
    endfunction

    localparam t_sig_rom SIG_ROM = build_sig_rom();

endpackage

// ----- hdl/nau_sigmoid.sv -----
`timescale 1ns / 1ps
// nau_sigmoid: combinational sigmoid, table lookup with linear interpolation
// depends on nau_pkg (widths, SIG_ROM)

module nau_sigmoid (
    input  logic signed [nau_pkg::DATA_WIDTH-1:0] i_arg,
    output logic        [nau_pkg::SIG_W-1:0]      o_sig
);

    localparam logic [nau_pkg::SIG_W-1:0] ONE_Q = nau_pkg::SIG_W'(1 << nau_pkg::FRAC_BITS);

    logic [nau_pkg::MAG_W-1:0]      mag;
    logic                           neg;
    logic                           sat;
    logic [nau_pkg::TABLE_BITS-1:0] idx;
    logic [nau_pkg::ROM_IDX_W-1:0]  idx_lo;
    logic [nau_pkg::ROM_IDX_W-1:0]  idx_hi;
    logic [nau_pkg::IDX_SHIFT-1:0]  frac;
    logic [nau_pkg::SIG_W-1:0]      lo_val;
    logic [nau_pkg::SIG_W-1:0]      hi_val;
    logic [nau_pkg::SIG_W-1:0]      diff;
    logic [nau_pkg::SIG_W+nau_pkg::IDX_SHIFT-1:0] prod;
    logic [nau_pkg::SIG_W-1:0]      interp;
    logic [nau_pkg::SIG_W-1:0]      s_mag;

    always_comb begin
        neg = i_arg[nau_pkg::DATA_WIDTH-1];
        mag = neg ? (nau_pkg::MAG_W'(0) - nau_pkg::MAG_W'(i_arg)) : nau_pkg::MAG_W'(i_arg);
        sat = (mag >= nau_pkg::MAG_W'(nau_pkg::SPAN_Q));

        idx    = mag[nau_pkg::IDX_SHIFT +: nau_pkg::TABLE_BITS];
        frac   = mag[nau_pkg::IDX_SHIFT-1:0];
        idx_lo = nau_pkg::ROM_IDX_W'(idx);
        idx_hi = idx_lo + nau_pkg::ROM_IDX_W'(1);
        lo_val = nau_pkg::SIG_ROM[idx_lo];
        hi_val = nau_pkg::SIG_ROM[idx_hi];

        // table rises monotonically; clamp guards a flat or falling step
        diff   = (hi_val > lo_val) ? (hi_val - lo_val) : '0;
        prod   = (nau_pkg::SIG_W + nau_pkg::IDX_SHIFT)'(diff)
               * (nau_pkg::SIG_W + nau_pkg::IDX_SHIFT)'(frac);
        interp = lo_val + nau_pkg::SIG_W'(prod >> nau_pkg::IDX_SHIFT);

        s_mag  = sat ? ONE_Q : interp;
        // symmetry for negative arguments
        o_sig  = neg ? (ONE_Q - s_mag) : s_mag;
    end

endmodule

// ----- hdl/neural_activation_unit_top.sv -----
`timescale 1ns / 1ps
// neural_activation_unit_top: elementwise activation on a sample stream, APB mode register
// depends on nau_pkg and nau_sigmoid
//
//  channel     dir  handshake                    payload
//  s_axis      in   s_axis_tvalid/tready         tdata[15:0] sample_in, tlast last_in
//  m_axis      out  m_axis_tvalid/tready         tdata[15:0] sample_out, tlast last_out
//  apb         in   psel/penable/pwrite/pready   paddr 0: mode[2:0]
//
// one word per cycle sustained while m_axis_tready stays high; path: input register, then result register
// all arithmetic sits between those two registers: sigmoid table read, two small multiplies
// a full result register holds under back-pressure while the input register keeps one more word
// synchronous active-low reset empties both stages and sets mode to identity

module neural_activation_unit_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // stream in
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [nau_pkg::DATA_WIDTH-1:0] s_axis_tdata,  // [15:0] sample_in
    input  logic                          s_axis_tlast,   // last_in
    // stream out
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [nau_pkg::DATA_WIDTH-1:0] m_axis_tdata,  // [15:0] sample_out
    output logic                          m_axis_tlast,   // last_out
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nau_pkg::APB_AW-1:0]    paddr,
    input  logic [nau_pkg::APB_DW-1:0]    pwdata,
    output logic [nau_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    localparam int DW = nau_pkg::DATA_WIDTH;
    localparam logic signed [DW-1:0] MAX_V = DW'((1 << (DW - 1)) - 1);
    localparam logic signed [DW-1:0] MIN_V = ~MAX_V;
    localparam logic signed [DW-1:0] ONE_Q = DW'(1 << nau_pkg::FRAC_BITS);

    logic [nau_pkg::MODE_W-1:0] r_mode;
    logic                       r_in_vld;
    logic signed [DW-1:0]       r_in_data;
    logic                       r_in_last;
    logic                       r_out_vld;
    logic [DW-1:0]              r_out_data;
    logic                       r_out_last;

    logic                       adv;
    logic                       cfg_wr;
    logic signed [DW-1:0]       z2;
    logic signed [DW-1:0]       sig_arg;
    logic [nau_pkg::SIG_W-1:0]  sig_val;
    logic signed [DW-1:0]       tanh_v;
    logic signed [nau_pkg::LEAK_W-1:0] leak_prod;
    logic signed [DW-1:0]       leak_v;
    logic [DW-1:0]              n_out_data;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == nau_pkg::REG_MODE) ? nau_pkg::APB_DW'(r_mode) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= nau_pkg::MODE_IDENTITY;
        end else if (cfg_wr && (paddr[2] == nau_pkg::REG_MODE)) begin
            r_mode <= pwdata[nau_pkg::MODE_W-1:0];
        end
    end

    // stage handshake
    assign adv           = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || adv;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_vld <= s_axis_tvalid;
            end
            if (adv) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_data <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
        if (adv) begin
            r_out_data <= n_out_data;
            r_out_last <= r_in_last;
        end
    end

    // tanh argument 2z, saturated
    always_comb begin
        if (r_in_data[DW-1] == r_in_data[DW-2]) begin
            z2 = {r_in_data[DW-2:0], 1'b0};
        end else begin
            z2 = r_in_data[DW-1] ? MIN_V : MAX_V;
        end
        sig_arg = (r_mode == nau_pkg::MODE_TANH) ? z2 : r_in_data;
    end

    nau_sigmoid u_sigmoid (
        .i_arg (sig_arg),
        .o_sig (sig_val)
    );

    always_comb begin
        tanh_v    = $signed(DW'({sig_val, 1'b0})) - ONE_Q;
        // arithmetic shift floors the product
        leak_prod = nau_pkg::LEAK_W'(r_in_data) * nau_pkg::LEAK_W'(nau_pkg::LEAK_NUM);
        leak_v    = DW'(leak_prod >>> nau_pkg::LEAK_SHIFT);

        case (r_mode)
            nau_pkg::MODE_SIGMOID: n_out_data = DW'(sig_val);
            nau_pkg::MODE_TANH:    n_out_data = tanh_v;
            nau_pkg::MODE_RELU:    n_out_data = r_in_data[DW-1] ? '0 : r_in_data;
            nau_pkg::MODE_LEAKY:   n_out_data = r_in_data[DW-1] ? leak_v : r_in_data;
            default:               n_out_data = r_in_data;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_mode_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> r_mode == nau_pkg::MODE_IDENTITY)
        else $error("mode not identity after reset");

    a_relu_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_mode == nau_pkg::MODE_RELU |=> !m_axis_tdata[DW-1])
        else $error("relu result negative");

    a_sig_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_mode == nau_pkg::MODE_SIGMOID |=>
            !m_axis_tdata[DW-1] && ($signed(m_axis_tdata) <= ONE_Q))
        else $error("sigmoid result outside [0, 1]");

    a_tanh_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_mode == nau_pkg::MODE_TANH |=>
            ($signed(m_axis_tdata) <= ONE_Q) && ($signed(m_axis_tdata) >= -ONE_Q))
        else $error("tanh result outside [-1, 1]");

    a_held_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !adv |=> r_in_vld && $stable(r_in_data) && $stable(r_in_last))
        else $error("waiting input word lost or changed");
`endif

endmodule

// ----- dv/neural_activation_unit_top_tb.sv -----
`timescale 1ns / 1ps
// neural_activation_unit_top_tb: self-checking bench for the stream activation unit
// depends on nau_pkg and neural_activation_unit_top; words are scored against a local predictor

module neural_activation_unit_top_tb;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int DW              = nau_pkg::DATA_WIDTH;
    localparam int AW              = nau_pkg::APB_AW;
    localparam int PW              = nau_pkg::APB_DW;
    localparam int MW              = nau_pkg::MODE_W;
    localparam int SIG_POINTS      = 256;
    localparam longint Q_ONE       = longint'(1) << nau_pkg::FRAC_BITS;
    localparam longint Q_SPAN      = longint'(8) << nau_pkg::FRAC_BITS;
    localparam longint LEAK_MUL    = 41;
    localparam longint LEAK_DIV    = 4096;

    localparam logic [AW-1:0] ADDR_MODE   = 3'd0;
    localparam logic [AW-1:0] ADDR_SPARE  = 3'd4;
    localparam logic [MW-1:0] MODE_UNUSED = 3'd7;

    typedef struct packed {
        logic [DW-1:0] sample;
        logic          last;
    } t_act_word;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [DW-1:0]     s_axis_tdata;   // [15:0] sample_in
    logic              s_axis_tlast;   // last_in
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [DW-1:0]     m_axis_tdata;   // [15:0] sample_out
    logic              m_axis_tlast;   // last_out
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [AW-1:0]     paddr;
    logic [PW-1:0]     pwdata;
    logic [PW-1:0]     prdata;
    logic              pready;

    t_act_word         pending_acts[$];
    int unsigned       sig_tbl [0:SIG_POINTS];
    logic [MW-1:0]     cur_mode;
    int                err_cnt      = 0;
    int                cycle_cnt    = 0;
    int                tx_gap_pct   = 20;
    int                rx_stall_pct = 20;
    bit                hold_off_req = 1'b0;

    neural_activation_unit_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("%0t: run did not finish in %0d cycles", $time, CYCLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------- predictor ----------------

    // sigmoid samples over [0,8]; exp(-8/N) stepped in Q1.31 from a 24-term series
    task automatic fill_sig_table();
        longint unsigned step_d;
        longint unsigned term;
        longint unsigned q;
        longint unsigned e;
        longint unsigned den;
        int              k;
        step_d = (64'd1 << 34) / 64'(SIG_POINTS);
        term   = 64'd1 << 31;
        q      = term;
        e      = term;
        for (k = 1; k <= 24; k++) begin
            term = ((term * step_d + (64'd1 << 30)) >> 31) / 64'(k);
            if (k % 2 == 1) begin
                q = q - term;
            end else begin
                q = q + term;
            end
        end
        for (k = 0; k <= SIG_POINTS; k++) begin
            if (k > 0) begin
                e = (e * q + (64'd1 << 30)) >> 31;
            end
            den        = (64'd1 << 31) + e;
            sig_tbl[k] = 32'(((64'd1 << (nau_pkg::FRAC_BITS + 31)) + den / 2) / den);
        end
    endtask

    function automatic longint clamp_q(longint v);
        longint hi;
        hi = (longint'(1) << (DW - 1)) - 1;
        if (v > hi) begin
            return hi;
        end
        if (v < -hi - 1) begin
            return -hi - 1;
        end
        return v;
    endfunction

    function automatic longint sig_of_mag(longint mag);
        longint pos;
        longint idx;
        longint frac;
        longint lo;
        longint hi;
        if (mag >= Q_SPAN) begin
            return Q_ONE;
        end
        pos  = mag * SIG_POINTS;
        idx  = pos / Q_SPAN;
        frac = pos % Q_SPAN;
        if (idx >= SIG_POINTS) begin
            return Q_ONE;
        end
        lo = sig_tbl[idx];
        hi = sig_tbl[idx + 1];
        if (hi < lo) begin
            hi = lo;
        end
        return lo + ((hi - lo) * frac) / Q_SPAN;
    endfunction

    function automatic longint sigmoid_of(longint z);
        if (z >= 0) begin
            return sig_of_mag(z);
        end
        return Q_ONE - sig_of_mag(-z);
    endfunction

    function automatic t_act_word activate(logic [DW-1:0] raw, logic last_flag,
                                           logic [MW-1:0] m);
        longint    z;
        longint    r;
        t_act_word w;
        z = longint'($signed(raw));
        case (m)
            nau_pkg::MODE_SIGMOID: r = sigmoid_of(z);
            nau_pkg::MODE_TANH:    r = 2 * sigmoid_of(clamp_q(2 * z)) - Q_ONE;
            nau_pkg::MODE_RELU:    r = (z >= 0) ? z : 0;
            // floor of a negative product, done on the magnitude
            nau_pkg::MODE_LEAKY:   r = (z >= 0) ? z :
                                       -((-z * LEAK_MUL + LEAK_DIV - 1) / LEAK_DIV);
            default:               r = z;
        endcase
        w.sample = DW'(clamp_q(r));
        w.last   = last_flag;
        return w;
    endfunction

    // ---------------- stream and register drivers ----------------

    function automatic int pick_gap(int pct);
        if ($urandom_range(0, 99) >= pct) begin
            return 0;
        end
        if ($urandom_range(0, 9) < 8) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    task automatic send_word(logic [DW-1:0] sample, logic last_flag);
        int gap;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sample;
        s_axis_tlast  <= last_flag;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_acts.push_back(activate(sample, last_flag, cur_mode));
        gap = pick_gap(tx_gap_pct);
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic tx_stop();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drain();
        while (pending_acts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [AW-1:0] addr, logic [PW-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_MODE) begin
            cur_mode = data[MW-1:0];
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_mode_readback();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_MODE;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== PW'(cur_mode)) begin
            $display("%0t: mode readback expected %h got %h", $time, PW'(cur_mode), prdata);
            err_cnt++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // upper data bits are random, only the low field should stick
    task automatic set_mode(logic [MW-1:0] m);
        logic [PW-1:0] data;
        data         = $urandom();
        data[MW-1:0] = m;
        tx_stop();
        wait_drain();
        apb_write(ADDR_MODE, data);
        check_mode_readback();
    endtask

    function automatic logic [DW-1:0] rand_sample();
        logic [DW-1:0] corner [7] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff,
                                      16'h0001, 16'h4000, 16'hc000};
        case ($urandom_range(0, 9)) inside
            [0:4]:   return DW'($urandom_range(0, 65535));
            [5:7]:   return DW'($urandom_range(0, 4095)) - 16'd2048;
            8:       return corner[$urandom_range(0, 6)];
            // around the table breakpoints, both signs
            default: return DW'($urandom_range(0, 511) * 128 + $urandom_range(0, 2)) - 16'd1;
        endcase
    endfunction

    // ---------------- result checker ----------------

    always @(posedge i_clk) begin : act_check
        t_act_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_acts.size() == 0) begin
                $display("%0t: unexpected word, expected none got sample %h last %b",
                         $time, m_axis_tdata, m_axis_tlast);
                err_cnt++;
            end else begin
                want = pending_acts.pop_front();
                if (m_axis_tdata !== want.sample) begin
                    $display("%0t: sample expected %h got %h", $time, want.sample,
                             m_axis_tdata);
                    err_cnt++;
                end
                if (m_axis_tlast !== want.last) begin
                    $display("%0t: last expected %b got %b", $time, want.last,
                             m_axis_tlast);
                    err_cnt++;
                end
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin : rx_side
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                stall_left   = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                stall_left = pick_gap(rx_stall_pct);
            end
        end
    end

    // ---------------- tests ----------------

    task automatic test_directed();
        tx_gap_pct   = 20;
        rx_stall_pct = 20;
        // reset value of mode is identity
        check_mode_readback();
        send_word(16'h7fff, 1'b0);
        send_word(16'h8000, 1'b1);
        // write to an address past the mode register must not change mode
        tx_stop();
        wait_drain();
        apb_write(ADDR_SPARE, 32'h0000_0003);
        check_mode_readback();
        send_word(16'h0001, 1'b1);

        // sigmoid: saturated negative, top of range, zero, minus one
        set_mode(nau_pkg::MODE_SIGMOID);
        send_word(16'h8000, 1'b0);
        send_word(16'h7fff, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'hf000, 1'b1);

        // tanh: doubled argument clamps at both ends
        set_mode(nau_pkg::MODE_TANH);
        send_word(16'h4000, 1'b0);
        send_word(16'hbfff, 1'b0);
        send_word(16'h7fff, 1'b0);
        send_word(16'h8000, 1'b0);
        send_word(16'h0000, 1'b1);

        set_mode(nau_pkg::MODE_RELU);
        send_word(16'hffff, 1'b0);
        send_word(16'h8000, 1'b0);
        send_word(16'h7fff, 1'b1);

        // leaky: tiny negatives floor to minus one
        set_mode(nau_pkg::MODE_LEAKY);
        send_word(16'hffff, 1'b0);
        send_word(16'h8000, 1'b0);
        send_word(16'hff9c, 1'b0);
        send_word(16'h0001, 1'b1);

        // unassigned code behaves as identity
        set_mode(MODE_UNUSED);
        send_word(16'h8000, 1'b0);
        send_word(16'h1234, 1'b1);
        tx_stop();
    endtask

    task automatic test_random_phases();
        logic [MW-1:0] phase_mode [8];
        int            ph;
        int            n;
        phase_mode[0] = nau_pkg::MODE_TANH;
        phase_mode[1] = nau_pkg::MODE_SIGMOID;
        phase_mode[2] = nau_pkg::MODE_LEAKY;
        phase_mode[3] = nau_pkg::MODE_RELU;
        phase_mode[4] = nau_pkg::MODE_IDENTITY;
        for (ph = 5; ph < 8; ph++) begin
            phase_mode[ph] = MW'($urandom_range(0, 7));
        end
        for (ph = 0; ph < 8; ph++) begin
            set_mode(phase_mode[ph]);
            // one phase runs flat out on both sides
            if (ph == 2) begin
                tx_gap_pct   = 0;
                rx_stall_pct = 0;
            end else begin
                tx_gap_pct   = $urandom_range(5, 40);
                rx_stall_pct = $urandom_range(5, 40);
            end
            for (n = 0; n < 200; n++) begin
                send_word(rand_sample(), $urandom_range(0, 7) == 0);
            end
            tx_stop();
        end
    endtask

    task automatic test_backpressure();
        int n;
        set_mode(nau_pkg::MODE_TANH);
        tx_gap_pct   = 0;
        rx_stall_pct = 10;
        hold_off_req = 1'b1;
        for (n = 0; n < 40; n++) begin
            send_word(rand_sample(), $urandom_range(0, 1));
        end
        tx_stop();
    endtask

    task automatic test_drain_pause();
        int n;
        set_mode(nau_pkg::MODE_LEAKY);
        tx_gap_pct   = 10;
        rx_stall_pct = 30;
        for (n = 0; n < 25; n++) begin
            send_word(rand_sample(), $urandom_range(0, 1));
        end
        tx_stop();
        while (pending_acts.size() != 0) @(posedge i_clk);
        for (n = 0; n < 25; n++) begin
            send_word(rand_sample(), $urandom_range(0, 1));
        end
        tx_stop();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        cur_mode      = nau_pkg::MODE_IDENTITY;
        fill_sig_table();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_phases();
        test_backpressure();
        test_drain_pause();

        while (pending_acts.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/nau_pkg.sv
hdl/nau_sigmoid.sv
hdl/neural_activation_unit_top.sv
dv/neural_activation_unit_top_tb.sv
